// ===== sv/hep_pkg.sv =====
`timescale 1ns / 1ps

package hep_pkg;

  // Coherence format: unsigned Q0.COH_BITS carried on a 16-bit field.
  localparam int COH_BITS   = 16;
  localparam int COH_W      = 16;

  // Noise path: numerator ((1 - coh) << 32), quotient and square root widths.
  localparam int NUM_W      = COH_BITS + 32;
  localparam int NRT_W      = (NUM_W + 1) / 2;
  localparam int NDIV_STEPS = 8;
  localparam int NDIV_STG   = (NUM_W + NDIV_STEPS - 1) / NDIV_STEPS;
  localparam int NRT_STEPS  = 8;
  localparam int NRT_STG    = (NRT_W + NRT_STEPS - 1) / NRT_STEPS;
  localparam int NOISE_LAT  = 1 + NDIV_STG + NRT_STG;

  // Scale path: 48-bit quotient of phase_to_height * 2^46 / |den|.
  localparam int SCL_W      = 48;
  localparam int SDIV_STEPS = 3;
  localparam int SDIV_STG   = (SCL_W + SDIV_STEPS - 1) / SDIV_STEPS;
  localparam int SCL_LAT    = 4 + SDIV_STG;

  localparam int NOISE_DLY  = SCL_LAT - NOISE_LAT;

  // Sigma, square and final root.
  localparam int HALF_W     = SCL_W / 2;
  localparam int PROD_W     = SCL_W + NRT_W;
  localparam int SIG_W      = 31;
  localparam int RT_W       = 32;
  localparam int RT_STEPS   = 4;
  localparam int RT_STG     = (RT_W + RT_STEPS - 1) / RT_STEPS;
  localparam int POST_LAT   = 4 + RT_STG;

  localparam int PIPE_LEN   = 1 + SCL_LAT + POST_LAT;

  localparam logic [7:0]  VALID_MASK_CODE = 8'h10;
  localparam logic [31:0] MINUS_ONE_Q16   = 32'hFFFF_0000;
  localparam logic [31:0] SAT_POS         = 32'h7FFF_FFFF;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED    = 2'd0,
    REG_MASK_EN = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic vld;
    logic masked;
  } tag_t;

endpackage

// ===== sv/hep_scale.sv =====
`timescale 1ns / 1ps

module hep_scale import hep_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [31:0]       ph_i,
  input  logic signed [31:0] sn_i,
  input  logic signed [31:0] cs_i,
  input  logic signed [31:0] bn_i,
  input  logic signed [31:0] bp_i,
  output logic [SCL_W-1:0]  scale_o,
  output logic              bad_o
);

  logic signed [63:0] p1_q, p2_q;
  logic [31:0]        ph1_q, ph2_q, ph3_q;
  logic signed [64:0] den_q;
  logic signed [64:0] nden;
  logic [63:0]        dmag_q;

  logic [63:0]      r_q   [SDIV_STG+1];
  logic [SCL_W-1:0] n_q   [SDIV_STG+1];
  logic [63:0]      dv_q  [SDIV_STG+1];
  logic             bad_q [SDIV_STG+1];
  logic [63:0]      r_d   [SDIV_STG+1];
  logic [SCL_W-1:0] n_d   [SDIV_STG+1];
  logic [63:0]      dv_d  [SDIV_STG+1];
  logic             bad_d [SDIV_STG+1];

  assign nden = -den_q;

  // Seed the divider: top quotient bits are known zero unless |den| * 4 <= ph.
  always_comb begin
    logic [64:0]      t;
    logic [63:0]      r;
    logic [SCL_W-1:0] n;
    r_d[0]   = {34'b0, ph3_q[31:2]};
    n_d[0]   = {ph3_q[1:0], {(SCL_W-2){1'b0}}};
    dv_d[0]  = dmag_q;
    bad_d[0] = (dmag_q == 64'd0) || ({34'b0, ph3_q} >= {dmag_q, 2'b0});
    for (int g = 0; g < SDIV_STG; g++) begin
      r = r_q[g];
      n = n_q[g];
      for (int k = 0; k < SDIV_STEPS; k++) begin
        if (g * SDIV_STEPS + k < SCL_W) begin
          t = {r, n[SCL_W-1]};
          n = {n[SCL_W-2:0], 1'b0};
          if (t >= {1'b0, dv_q[g]}) begin
            t    = t - {1'b0, dv_q[g]};
            n[0] = 1'b1;
          end
          r = t[63:0];
        end
      end
      r_d[g+1]   = r;
      n_d[g+1]   = n;
      dv_d[g+1]  = dv_q[g];
      bad_d[g+1] = bad_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= bp_i * sn_i;
      p2_q   <= bn_i * cs_i;
      ph1_q  <= ph_i;
      den_q  <= -$signed({p1_q[63], p1_q}) - $signed({p2_q[63], p2_q});
      ph2_q  <= ph1_q;
      dmag_q <= den_q[64] ? nden[63:0] : den_q[63:0];
      ph3_q  <= ph2_q;
      for (int g = 0; g <= SDIV_STG; g++) begin
        r_q[g]   <= r_d[g];
        n_q[g]   <= n_d[g];
        dv_q[g]  <= dv_d[g];
        bad_q[g] <= bad_d[g];
      end
    end
  end

  assign scale_o = n_q[SDIV_STG];
  assign bad_o   = bad_q[SDIV_STG];

endmodule

// ===== sv/hep_noise.sv =====
`timescale 1ns / 1ps

module hep_noise import hep_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [COH_W-1:0] coh_i,
  output logic [NRT_W-1:0] noise_o
);

  logic [COH_BITS:0] diff;

  logic [COH_W-1:0] r_q  [NDIV_STG+1];
  logic [NUM_W-1:0] n_q  [NDIV_STG+1];
  logic [COH_W-1:0] dv_q [NDIV_STG+1];
  logic             zf_q [NDIV_STG+1];
  logic [COH_W-1:0] r_d  [NDIV_STG+1];
  logic [NUM_W-1:0] n_d  [NDIV_STG+1];
  logic [COH_W-1:0] dv_d [NDIV_STG+1];
  logic             zf_d [NDIV_STG+1];

  logic [2*NRT_W-1:0] rad_q [NRT_STG];
  logic [NRT_W:0]     rem_q [NRT_STG];
  logic [NRT_W-1:0]   res_q [NRT_STG];
  logic               szf_q [NRT_STG];
  logic [2*NRT_W-1:0] rad_d [NRT_STG];
  logic [NRT_W:0]     rem_d [NRT_STG];
  logic [NRT_W-1:0]   res_d [NRT_STG];
  logic               szf_d [NRT_STG];

  assign diff = ((COH_BITS+1)'(1) << COH_BITS) - (COH_BITS+1)'(coh_i);

  always_comb begin
    logic [COH_W:0]     t;
    logic [COH_W-1:0]   r;
    logic [NUM_W-1:0]   n;
    logic [2*NRT_W-1:0] rad;
    logic [NRT_W:0]     rem;
    logic [NRT_W-1:0]   res;
    logic [NRT_W+2:0]   ts;
    logic [NRT_W+2:0]   tr;
    logic               zf;
    r_d[0]  = '0;
    n_d[0]  = {diff[COH_BITS-1:0], 32'b0};
    dv_d[0] = coh_i;
    zf_d[0] = (coh_i == '0) || (32'(coh_i) >= (32'd1 << COH_BITS));
    for (int g = 0; g < NDIV_STG; g++) begin
      r = r_q[g];
      n = n_q[g];
      for (int k = 0; k < NDIV_STEPS; k++) begin
        if (g * NDIV_STEPS + k < NUM_W) begin
          t = {r, n[NUM_W-1]};
          n = {n[NUM_W-2:0], 1'b0};
          if (t >= {1'b0, dv_q[g]}) begin
            t    = t - {1'b0, dv_q[g]};
            n[0] = 1'b1;
          end
          r = t[COH_W-1:0];
        end
      end
      r_d[g+1]  = r;
      n_d[g+1]  = n;
      dv_d[g+1] = dv_q[g];
      zf_d[g+1] = zf_q[g];
    end
    // Square root, two radicand bits per step.
    for (int j = 0; j < NRT_STG; j++) begin
      if (j == 0) begin
        rad = (2*NRT_W)'(n_q[NDIV_STG]);
        rem = '0;
        res = '0;
        zf  = zf_q[NDIV_STG];
      end else begin
        rad = rad_q[j-1];
        rem = rem_q[j-1];
        res = res_q[j-1];
        zf  = szf_q[j-1];
      end
      for (int k = 0; k < NRT_STEPS; k++) begin
        if (j * NRT_STEPS + k < NRT_W) begin
          ts  = {rem, rad[2*NRT_W-1 -: 2]};
          rad = {rad[2*NRT_W-3:0], 2'b00};
          tr  = {1'b0, res, 2'b01};
          if (ts >= tr) begin
            ts  = ts - tr;
            res = {res[NRT_W-2:0], 1'b1};
          end else begin
            res = {res[NRT_W-2:0], 1'b0};
          end
          rem = ts[NRT_W:0];
        end
      end
      rad_d[j] = rad;
      rem_d[j] = rem;
      res_d[j] = res;
      szf_d[j] = zf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g <= NDIV_STG; g++) begin
        r_q[g]  <= r_d[g];
        n_q[g]  <= n_d[g];
        dv_q[g] <= dv_d[g];
        zf_q[g] <= zf_d[g];
      end
      for (int j = 0; j < NRT_STG; j++) begin
        rad_q[j] <= rad_d[j];
        rem_q[j] <= rem_d[j];
        res_q[j] <= res_d[j];
        szf_q[j] <= szf_d[j];
      end
    end
  end

  // Drop the noise term for zero coherence or coherence at one.
  assign noise_o = szf_q[NRT_STG-1] ? '0 : res_q[NRT_STG-1];

endmodule

// ===== sv/hep_sigma.sv =====
`timescale 1ns / 1ps

module hep_sigma import hep_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SCL_W-1:0] scale_i,
  input  logic [NRT_W-1:0] noise_i,
  input  logic             bad_i,
  input  logic [31:0]      seed_i,
  output logic [RT_W-1:0]  root_o,
  output logic             sat_o
);

  logic [HALF_W+NRT_W-1:0] pl_q, phi_q;
  logic                    sat1_q, sat2_q, sat3_q;
  logic [PROD_W-1:0]       prod;
  logic [SIG_W-1:0]        sig_q;
  logic [2*SIG_W-1:0]      sq_q;

  logic [2*RT_W-1:0] rad_q [RT_STG+1];
  logic [RT_W:0]     rem_q [RT_STG+1];
  logic [RT_W-1:0]   res_q [RT_STG+1];
  logic              sat_q [RT_STG+1];
  logic [2*RT_W-1:0] rad_d [RT_STG+1];
  logic [RT_W:0]     rem_d [RT_STG+1];
  logic [RT_W-1:0]   res_d [RT_STG+1];
  logic              sat_d [RT_STG+1];

  assign prod = {phi_q, {HALF_W{1'b0}}} + PROD_W'(pl_q);

  always_comb begin
    logic [2*RT_W-1:0] rad;
    logic [RT_W:0]     rem;
    logic [RT_W-1:0]   res;
    logic [RT_W+2:0]   ts;
    logic [RT_W+2:0]   tr;
    rad_d[0] = (2*RT_W)'(sq_q) + ((2*RT_W)'(seed_i) << 16);
    rem_d[0] = '0;
    res_d[0] = '0;
    sat_d[0] = sat3_q;
    for (int g = 0; g < RT_STG; g++) begin
      rad = rad_q[g];
      rem = rem_q[g];
      res = res_q[g];
      for (int k = 0; k < RT_STEPS; k++) begin
        if (g * RT_STEPS + k < RT_W) begin
          ts  = {rem, rad[2*RT_W-1 -: 2]};
          rad = {rad[2*RT_W-3:0], 2'b00};
          tr  = {1'b0, res, 2'b01};
          if (ts >= tr) begin
            ts  = ts - tr;
            res = {res[RT_W-2:0], 1'b1};
          end else begin
            res = {res[RT_W-2:0], 1'b0};
          end
          rem = ts[RT_W:0];
        end
      end
      rad_d[g+1] = rad;
      rem_d[g+1] = rem;
      res_d[g+1] = res;
      sat_d[g+1] = sat_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= (HALF_W+NRT_W)'(scale_i[HALF_W-1:0]) * (HALF_W+NRT_W)'(noise_i);
      phi_q  <= (HALF_W+NRT_W)'(scale_i[SCL_W-1:HALF_W]) * (HALF_W+NRT_W)'(noise_i);
      sat1_q <= bad_i;
      // sigma must stay below 2^31, so the product must stay below 2^47.
      sat2_q <= sat1_q || (prod[PROD_W-1:SIG_W+16] != '0);
      sig_q  <= prod[SIG_W+15:16];
      sq_q   <= (2*SIG_W)'(sig_q) * (2*SIG_W)'(sig_q);
      sat3_q <= sat2_q;
      for (int g = 0; g <= RT_STG; g++) begin
        rad_q[g] <= rad_d[g];
        rem_q[g] <= rem_d[g];
        res_q[g] <= res_d[g];
        sat_q[g] <= sat_d[g];
      end
    end
  end

  assign root_o = res_q[RT_STG];
  assign sat_o  = sat_q[RT_STG] || res_q[RT_STG][RT_W-1];

endmodule

// ===== sv/insar_height_error_pixel.sv =====
`timescale 1ns / 1ps
// Pipeline: a result passes the input register, 20 baseline/divider stages and
// 12 sigma/root stages, then the output register.
// Throughput: one pixel per clock while a stalled output does not freeze the
// pipeline; the 3-bit-per-stage quotient pipeline sets the depth.
// A stalled output freezes the pipeline only when its last stage holds a pixel.
// Reset clears valid bits, the output valid and both configuration registers.
module insar_height_error_pixel import hep_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          coherence_i,
  input  logic [31:0]          phase_to_height_i,
  input  logic signed [31:0]   sin_flat_i,
  input  logic signed [31:0]   cos_flat_i,
  input  logic signed [31:0]   baseline_normal_i,
  input  logic signed [31:0]   baseline_parallel_i,
  input  logic [7:0]           mask_code_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   height_error_o,
  output logic                 masked_o,
  output logic                 saturated_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  logic [31:0] seed_error_squared_q;
  logic        mask_enable_q;

  // Pixel register at the pipeline entry.
  logic [15:0]        coh_q;
  logic [31:0]        ph_q;
  logic signed [31:0] sn_q, cs_q, bn_q, bp_q;

  // Valid and mask flag travel beside the data through every stage.
  tag_t tag_q [PIPE_LEN];
  tag_t tag_last;
  logic en;

  logic [SCL_W-1:0] scale;
  logic             bad;
  logic [NRT_W-1:0] noise_raw;
  logic [NRT_W-1:0] noise;
  logic [RT_W-1:0]  root;
  logic             root_sat;

  logic               out_valid_q;
  logic signed [31:0] height_q;
  logic               masked_q;
  logic               sat_q;

  assign tag_last = tag_q[PIPE_LEN-1];

  // Advance unless a finished pixel in the last stage cannot leave.
  assign en          = !(tag_last.vld && out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_error_squared_q <= '0;
      mask_enable_q        <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SEED:    seed_error_squared_q <= cfg_data_i;
        REG_MASK_EN: mask_enable_q        <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      coh_q <= coherence_i;
      ph_q  <= phase_to_height_i;
      sn_q  <= sin_flat_i;
      cs_q  <= cos_flat_i;
      bn_q  <= baseline_normal_i;
      bp_q  <= baseline_parallel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_LEN; i++) tag_q[i] <= '0;
    end else if (en) begin
      tag_q[0].vld    <= in_valid_i;
      tag_q[0].masked <= mask_enable_q && (mask_code_i != VALID_MASK_CODE);
      for (int i = 1; i < PIPE_LEN; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  // Baseline denominator and phase-to-height scale.
  hep_scale u_scale (
    .clk_i   (clk_i),
    .en_i    (en),
    .ph_i    (ph_q),
    .sn_i    (sn_q),
    .cs_i    (cs_q),
    .bn_i    (bn_q),
    .bp_i    (bp_q),
    .scale_o (scale),
    .bad_o   (bad)
  );

  // Coherence noise term, ready before the scale.
  hep_noise u_noise (
    .clk_i   (clk_i),
    .en_i    (en),
    .coh_i   (coh_q),
    .noise_o (noise_raw)
  );

  // Hold the noise term until the scale catches up.
  generate
    if (NOISE_DLY > 0) begin : g_noise_dly
      logic [NRT_W-1:0] nd_q [NOISE_DLY];
      always_ff @(posedge clk_i) begin
        if (en) begin
          nd_q[0] <= noise_raw;
          for (int i = 1; i < NOISE_DLY; i++) nd_q[i] <= nd_q[i-1];
        end
      end
      assign noise = nd_q[NOISE_DLY-1];
    end else begin : g_noise_now
      assign noise = noise_raw;
    end
  endgenerate

  // Sigma, sum with seed error, final root.
  hep_sigma u_sigma (
    .clk_i   (clk_i),
    .en_i    (en),
    .scale_i (scale),
    .noise_i (noise),
    .bad_i   (bad),
    .seed_i  (seed_error_squared_q),
    .root_o  (root),
    .sat_o   (root_sat)
  );

  // Output register: masking wins over saturation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= tag_last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (tag_last.masked) begin
        height_q <= MINUS_ONE_Q16;
        masked_q <= 1'b1;
        sat_q    <= 1'b0;
      end else if (root_sat) begin
        height_q <= SAT_POS;
        masked_q <= 1'b0;
        sat_q    <= 1'b1;
      end else begin
        height_q <= root;
        masked_q <= 1'b0;
        sat_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign height_error_o = height_q;
  assign masked_o       = masked_q;
  assign saturated_o    = sat_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(masked_o && saturated_o))
    else $error("masked and saturated both set");

  a_masked_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && masked_o) |-> (height_error_o == MINUS_ONE_Q16))
    else $error("masked pixel without -1.0");

  a_sat_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (height_error_o == SAT_POS))
    else $error("saturated pixel without full-scale value");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(tag_last))
    else $error("last stage changed during a freeze");

endmodule

// ===== test/tb_insar_height_error_pixel.sv =====
`timescale 1ns / 1ps

module tb_insar_height_error_pixel;
  import hep_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Pixel request channel
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] coherence_i = '0;
  logic [31:0] phase_to_height_i = '0;
  logic signed [31:0] sin_flat_i = '0;
  logic signed [31:0] cos_flat_i = '0;
  logic signed [31:0] baseline_normal_i = '0;
  logic signed [31:0] baseline_parallel_i = '0;
  logic [7:0]  mask_code_i = '0;

  // Result channel
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] height_error_o;
  logic        masked_o;
  logic        saturated_o;

  // Register write channel
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  typedef struct packed {
    logic [31:0] height_error;
    logic        masked;
    logic        saturated;
  } pixel_result_t;

  typedef struct packed {
    logic [15:0] coh;
    logic [31:0] ph;
    logic [31:0] sn;
    logic [31:0] cs;
    logic [31:0] bn;
    logic [31:0] bp;
    logic [7:0]  mcode;
  } pixel_t;

  pixel_result_t pending_results[$];

  // Local copy of the block's registers
  logic [31:0] seed_err_sq;
  logic        mask_on;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int mismatches = 0;

  insar_height_error_pixel dut (.*);

  always #6 clk_i = ~clk_i;

  // Integer square root, floor, of a 64-bit value (bit-pair method).
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem = n;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Work out the height error of one pixel under the current register values.
  function automatic pixel_result_t height_error_of(input pixel_t p);
    pixel_result_t r;
    logic signed [63:0] den;
    logic [63:0] dmag;
    logic [127:0] numer;
    logic [127:0] quot;
    logic [63:0] scale;
    logic [63:0] noise;
    logic [63:0] prod;
    logic [63:0] sigma;
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] one;
    r.masked = 1'b0;
    r.saturated = 1'b1;
    r.height_error = SAT_POS;
    if (mask_on && p.mcode != VALID_MASK_CODE) begin
      r.height_error = MINUS_ONE_Q16;
      r.masked = 1'b1;
      r.saturated = 1'b0;
      return r;
    end
    // Products of two signed 32-bit values, then the 64-bit wrap
    den = -($signed(p.bp) * $signed(p.sn)) - ($signed(p.bn) * $signed(p.cs));
    dmag = den[63] ? -den : den;
    if (dmag == 0) return r;
    numer = {64'd0, p.ph} << 46;
    quot = numer / {64'd0, dmag};
    if (quot >= (128'd1 << 48)) return r;
    scale = quot[63:0];
    one = 64'd1 << COH_BITS;
    if (p.coh == 0 || p.coh >= one) noise = 0;
    else noise = floor_sqrt(((one - p.coh) << 32) / p.coh);
    if (noise != 0 && scale > ((64'd1 << 63) / noise)) return r;
    prod = scale * noise;
    sigma = prod >> 16;
    if (sigma >= (64'd1 << 31)) return r;
    sq = sigma * sigma + ({32'd0, seed_err_sq} << 16);
    root = floor_sqrt(sq);
    if (root > SAT_POS) return r;
    r.height_error = root[31:0];
    r.saturated = 1'b0;
    return r;
  endfunction

  // Send one pixel; predict at acceptance so register state matches.
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coherence_i <= p.coh;
    phase_to_height_i <= p.ph;
    sin_flat_i <= p.sn;
    cos_flat_i <= p.cs;
    baseline_normal_i <= p.bn;
    baseline_parallel_i <= p.bp;
    mask_code_i <= p.mcode;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(height_error_of(p));
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  // Drain outstanding results, then hold idle past the pipeline depth.
  task automatic drain();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LEN + 4) @(posedge clk_i);
  endtask

  // Write one register, then return the channel to idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_SEED) seed_err_sq = val;
    else if (idx == REG_MASK_EN) mask_on = val[0];
    @(posedge clk_i);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int sel;
    p.coh = $urandom;
    p.ph = $urandom;
    p.sn = $urandom;
    p.cs = $urandom;
    p.bn = $urandom;
    p.bp = $urandom;
    p.mcode = ($urandom_range(3) == 0) ? 8'($urandom) : VALID_MASK_CODE;
    sel = $urandom_range(9);
    // Bias toward realistic geometry so the full root path is exercised
    if (sel < 6) begin
      p.sn = $signed($urandom_range(2147483647)) - 32'sd1073741824;
      p.cs = $signed($urandom_range(2147483647)) - 32'sd1073741824;
      p.bn = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
      p.bp = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
      p.ph = $urandom_range(32'h0100_0000);
      if (sel < 2) p.coh = $urandom_range(65535, 60000);
    end else if (sel == 6) begin
      p.coh = 0;
    end else if (sel == 7) begin
      p.ph = $urandom_range(255);
    end
    return p;
  endfunction

  // Check each result against the oldest expectation.
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", height_error_o);
      end else begin
        want = pending_results.pop_front();
        if (want.height_error !== height_error_o || want.masked !== masked_o ||
            want.saturated !== saturated_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h m%0d s%0d, got %h m%0d s%0d",
                     want.height_error, want.masked, want.saturated,
                     height_error_o, masked_o, saturated_o);
        end
      end
    end
  end

  // Receiver stall, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic test_directed();
    pixel_t p;
    int k;
    p = '{coh: 16'h8000, ph: 32'h0001_0000, sn: 32'h2000_0000, cs: 32'h3000_0000,
          bn: 32'h0064_0000, bp: 32'hFFCE_0000, mcode: VALID_MASK_CODE};
    send_pixel(p);
    p.coh = 16'h0000; send_pixel(p);          // zero coherence
    p.coh = 16'hFFFF; send_pixel(p);
    p.coh = 16'h0001; send_pixel(p);
    p.coh = 16'h4000; p.bn = 0; p.bp = 0; send_pixel(p);   // zero denominator
    p.sn = 0; p.cs = 0; p.bn = 32'h7FFF_FFFF; send_pixel(p);
    p = '{coh: 16'h0001, ph: 32'hFFFF_FFFF, sn: 32'h0000_0001, cs: 32'h0,
          bn: 32'h0, bp: 32'h0000_0001, mcode: 8'hFF};      // scale overflow
    send_pixel(p);
    p.ph = 32'h0000_0001; send_pixel(p);
    p.sn = 32'h4000_0000; p.cs = 32'hC000_0000; p.bn = 32'h8000_0000;
    p.bp = 32'h7FFF_FFFF; send_pixel(p);
    p.sn = 32'h8000_0000; p.cs = 32'h7FFF_FFFF; p.coh = 16'h0100; send_pixel(p);
    p = '{coh: 16'hF000, ph: 32'h0000_0000, sn: 32'h1000_0000, cs: 32'h1000_0000,
          bn: 32'h0001_0000, bp: 32'h0001_0000, mcode: 8'h00};
    send_pixel(p);                             // zero scale, seed only
    for (k = 0; k < 6; k++) begin
      p.ph = $urandom_range(32'h0010_0000);
      p.coh = $urandom_range(65535, 1);
      send_pixel(p);
    end
    drain();
  endtask

  task automatic test_masking();
    pixel_t p;
    int k;
    write_reg(REG_MASK_EN, 32'd1);
    write_reg(REG_SEED, 32'hFFFF_FFFF);        // largest seed value
    p = random_pixel();
    p.mcode = VALID_MASK_CODE; send_pixel(p);
    p.mcode = 8'h00; send_pixel(p);
    p.mcode = 8'hFF; send_pixel(p);
    p.mcode = 8'h11; send_pixel(p);
    p.bn = 0; p.bp = 0; send_pixel(p);         // masked wins over zero denominator
    for (k = 0; k < 8; k++) send_pixel(random_pixel());
    drain();
  endtask

  task automatic test_random(input int count, input int unsigned idle, input int unsigned stall);
    int k;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (k = 0; k < count; k++) begin
      if (k % 50 == 0 && k != 0) begin
        drain();
        write_reg(REG_SEED, ($urandom_range(3) == 0) ? 32'd0 : $urandom);
        write_reg(REG_MASK_EN, $urandom_range(1));
      end
      send_pixel(random_pixel());
    end
    drain();
  endtask

  initial begin
    seed_err_sq = '0;
    mask_on = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_masking();
    write_reg(REG_SEED, 32'd0);
    write_reg(REG_MASK_EN, 32'd0);
    test_random(150, 11, 60);
    test_random(150, 60, 11);
    test_random(100, 0, 0);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/hep_pkg.sv
sv/hep_scale.sv
sv/hep_noise.sv
sv/hep_sigma.sv
sv/insar_height_error_pixel.sv
test/tb_insar_height_error_pixel.sv
